FILE: rtl/mouse_packet_cursor_tracker_top_macros.svh
// Assertion macros shared by the cursor tracker RTL.
`ifndef MOUSE_PACKET_CURSOR_TRACKER_TOP_MACROS_SVH
`define MOUSE_PACKET_CURSOR_TRACKER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MPCT_ASSERT_IMPLIES(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("mpct: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define MPCT_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("mpct: next-cycle check failed");

`endif

FILE: rtl/mpct_pkg.sv
// Types and constants shared by the cursor tracker modules.
package mpct_pkg;

    localparam int DIM_BITS = 14;

    // One input item as held in the input register.
    typedef struct packed {
        logic       op;
        logic [7:0] data_byte;
        logic       from_aux;
    } item_t;

    // Screen size as seen by the packet logic.
    typedef struct packed {
        logic [DIM_BITS-1:0] width;
        logic [DIM_BITS-1:0] height;
    } screen_cfg_t;

    // Item operation codes.
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_INIT = 1'b1;

    // Result event codes.
    localparam logic [2:0] EV_IGNORED  = 3'd0;
    localparam logic [2:0] EV_RESYNC   = 3'd1;
    localparam logic [2:0] EV_STORED   = 3'd2;
    localparam logic [2:0] EV_APPLIED  = 3'd3;
    localparam logic [2:0] EV_OVERFLOW = 3'd4;
    localparam logic [2:0] EV_INIT     = 3'd5;

    // Packet byte phase codes.
    localparam logic [1:0] PH_FIRST  = 2'd0;
    localparam logic [1:0] PH_SECOND = 2'd1;
    localparam logic [1:0] PH_THIRD  = 2'd2;
    localparam logic [1:0] PH_SPARE  = 2'd3;

    // Bit positions in the flags byte.
    localparam int SYNC_BIT  = 3;
    localparam int XSIGN_BIT = 4;
    localparam int YSIGN_BIT = 5;
    localparam int XOVF_BIT  = 6;
    localparam int YOVF_BIT  = 7;

    // Register indexes, decoded from paddr[2].
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    localparam logic [DIM_BITS-1:0] WIDTH_RESET  = 14'd640;
    localparam logic [DIM_BITS-1:0] HEIGHT_RESET = 14'd480;

endpackage

FILE: rtl/mpct_regs.sv
// APB-style configuration registers holding the screen size.
module mpct_regs (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    output mpct_pkg::screen_cfg_t cfg
);
    import mpct_pkg::*;

    logic [DIM_BITS-1:0] width_reg;
    logic [DIM_BITS-1:0] height_reg;
    logic                wr_en;

    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end else if (wr_en) begin
            unique case (paddr[2])
                REG_WIDTH:  width_reg  <= pwdata[DIM_BITS-1:0];
                REG_HEIGHT: height_reg <= pwdata[DIM_BITS-1:0];
                default:    ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_WIDTH:  prdata = {{(32-DIM_BITS){1'b0}}, width_reg};
            REG_HEIGHT: prdata = {{(32-DIM_BITS){1'b0}}, height_reg};
            default:    prdata = '0;
        endcase
    end

    assign cfg.width  = width_reg;
    assign cfg.height = height_reg;

endmodule

FILE: rtl/mpct_core.sv
// Packet assembly state and combinational cursor update logic.
`include "mouse_packet_cursor_tracker_top_macros.svh"
module mpct_core #(
    parameter int COORD_BITS = 13
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  fire,
    input  mpct_pkg::item_t       item,
    input  mpct_pkg::screen_cfg_t cfg,
    output logic [2:0]            event_next,
    output logic [COORD_BITS-1:0] x_next,
    output logic [COORD_BITS-1:0] y_next,
    output logic [2:0]            buttons_next,
    output logic [31:0]           count_next
);
    import mpct_pkg::*;

    // Width for dimension arithmetic, and signed width for position sums.
    localparam int LW = ((COORD_BITS > DIM_BITS) ? COORD_BITS : DIM_BITS) + 1;
    localparam int SW = COORD_BITS + 2;
    localparam logic [LW-1:0] COORD_MAX_L = LW'((1 << COORD_BITS) - 1);

    logic [COORD_BITS-1:0] pos_x_reg;
    logic [COORD_BITS-1:0] pos_y_reg;
    logic [2:0]            buttons_reg;
    logic [31:0]           count_reg;
    logic [1:0]            phase_reg;
    logic [1:0]            phase_next;
    logic [7:0]            first_reg;
    logic [7:0]            first_next;
    logic [7:0]            second_reg;
    logic [7:0]            second_next;
    logic                  ready_reg;
    logic                  ready_next;

    logic signed [9:0]     dx;
    logic signed [9:0]     neg_dy;

    function automatic logic [COORD_BITS-1:0] sat_coord(input logic [LW-1:0] v);
        return (v > COORD_MAX_L) ? COORD_MAX_L[COORD_BITS-1:0] : v[COORD_BITS-1:0];
    endfunction

    function automatic logic [COORD_BITS-1:0] limit_of(input logic [DIM_BITS-1:0] dim);
        logic [LW-1:0] d;
        d = LW'(dim);
        if (dim == '0) begin
            return '0;
        end
        return sat_coord(d - LW'(1));
    endfunction

    function automatic logic [COORD_BITS-1:0] centre_of(input logic [DIM_BITS-1:0] dim);
        logic [LW-1:0] d;
        d = LW'(dim) >> 1;
        return sat_coord(d);
    endfunction

    function automatic logic [COORD_BITS-1:0] move_clamped(
        input logic [COORD_BITS-1:0] pos,
        input logic signed [9:0]     delta,
        input logic [COORD_BITS-1:0] limit
    );
        logic signed [SW-1:0] v;
        logic signed [SW-1:0] lim;
        v   = $signed({2'b00, pos}) + SW'(delta);
        lim = $signed({2'b00, limit});
        if (v < 0) begin
            return '0;
        end
        if (v > lim) begin
            return limit;
        end
        return v[COORD_BITS-1:0];
    endfunction

    // Motion is 9-bit two's complement with the sign held in the flags byte.
    assign dx     = $signed({first_reg[XSIGN_BIT], first_reg[XSIGN_BIT], second_reg});
    assign neg_dy = 10'sd0 - $signed({first_reg[YSIGN_BIT], first_reg[YSIGN_BIT],
                                      item.data_byte});

    always_comb begin
        event_next   = EV_IGNORED;
        x_next       = pos_x_reg;
        y_next       = pos_y_reg;
        buttons_next = buttons_reg;
        count_next   = count_reg;
        phase_next   = phase_reg;
        first_next   = first_reg;
        second_next  = second_reg;
        ready_next   = ready_reg;
        if (item.op == OP_INIT) begin
            if (cfg.width != '0 && cfg.height != '0) begin
                x_next = centre_of(cfg.width);
                y_next = centre_of(cfg.height);
            end
            phase_next = PH_FIRST;
            ready_next = 1'b1;
            event_next = EV_INIT;
        end else if (item.from_aux && ready_reg) begin
            case (phase_reg)
                PH_FIRST: begin
                    if (!item.data_byte[SYNC_BIT]) begin
                        event_next = EV_RESYNC;
                    end else begin
                        first_next = item.data_byte;
                        phase_next = PH_SECOND;
                        event_next = EV_STORED;
                    end
                end
                PH_SECOND: begin
                    second_next = item.data_byte;
                    phase_next  = PH_THIRD;
                    event_next  = EV_STORED;
                end
                default: begin
                    // Third byte completes the packet.
                    phase_next = PH_FIRST;
                    if (first_reg[XOVF_BIT] || first_reg[YOVF_BIT]) begin
                        event_next = EV_OVERFLOW;
                    end else begin
                        x_next       = move_clamped(pos_x_reg, dx, limit_of(cfg.width));
                        y_next       = move_clamped(pos_y_reg, neg_dy, limit_of(cfg.height));
                        buttons_next = first_reg[2:0];
                        count_next   = count_reg + 32'd1;
                        event_next   = EV_APPLIED;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_x_reg   <= '0;
            pos_y_reg   <= '0;
            buttons_reg <= '0;
            count_reg   <= '0;
            phase_reg   <= PH_FIRST;
            ready_reg   <= 1'b0;
        end else if (fire) begin
            pos_x_reg   <= x_next;
            pos_y_reg   <= y_next;
            buttons_reg <= buttons_next;
            count_reg   <= count_next;
            phase_reg   <= phase_next;
            ready_reg   <= ready_next;
        end
    end

    // Packet bytes carry no reset; the phase keeps them from being read unwritten.
    always_ff @(posedge aclk) begin
        if (fire) begin
            first_reg  <= first_next;
            second_reg <= second_next;
        end
    end

    `MPCT_ASSERT_IMPLIES(a_phase_legal, aclk, aresetn, 1'b1, phase_reg != PH_SPARE)
    `MPCT_ASSERT_NEXT(a_count_step, aclk, aresetn, fire && event_next == EV_APPLIED, count_reg == $past(count_reg) + 32'd1)

endmodule

FILE: rtl/mouse_packet_cursor_tracker_top.sv
// Top level of the PS/2 mouse packet cursor tracker.
//
//  Channel  | Direction | Handshake                   | Payload
//  ---------+-----------+-----------------------------+---------------------------------
//  s_       | in        | s_valid / s_ready           | op, data_byte, from_aux
//  m_       | out       | m_valid / m_ready           | event_res, cursor_x/y, buttons,
//           |           |                             | packet_count
//  APB      | in/out    | psel, penable, pwrite,pready| paddr, pwdata, prdata
//
// Each item passes from input transfer to result through the input register,
// then through the packet update logic into the result register.
// The block sustains one item per cycle while the result does not stall.
// State and result registers load in the same cycle, so a following item sees them.
// Reset is synchronous and active low; it clears the cursor, buttons, count,
// phase and the ready flag, and restores a 640 by 480 screen.
// A stalled result holds in the result register while an empty input register
// still takes one more item, so the input side keeps moving for one transfer.
`include "mouse_packet_cursor_tracker_top_macros.svh"
module mouse_packet_cursor_tracker_top #(
    parameter int COORD_BITS = 13
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_op,
    input  logic [7:0]            s_data_byte,
    input  logic                  s_from_aux,

    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [2:0]            m_event_res,
    output logic [COORD_BITS-1:0] m_cursor_x,
    output logic [COORD_BITS-1:0] m_cursor_y,
    output logic [2:0]            m_buttons,
    output logic [31:0]           m_packet_count,

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);
    import mpct_pkg::*;

    screen_cfg_t           cfg;
    item_t                 item_reg;
    logic                  in_valid_reg;
    logic                  advance;

    logic [2:0]            event_next;
    logic [COORD_BITS-1:0] x_next;
    logic [COORD_BITS-1:0] y_next;
    logic [2:0]            buttons_next;
    logic [31:0]           count_next;

    logic                  out_valid_reg;
    logic [2:0]            event_reg;
    logic [COORD_BITS-1:0] cursor_x_reg;
    logic [COORD_BITS-1:0] cursor_y_reg;
    logic [2:0]            buttons_reg;
    logic [31:0]           count_reg;

    mpct_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // The held item moves on whenever the result register is free or draining.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg.op        <= s_op;
            item_reg.data_byte <= s_data_byte;
            item_reg.from_aux  <= s_from_aux;
        end
    end

    mpct_core #(
        .COORD_BITS (COORD_BITS)
    ) u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .fire         (advance),
        .item         (item_reg),
        .cfg          (cfg),
        .event_next   (event_next),
        .x_next       (x_next),
        .y_next       (y_next),
        .buttons_next (buttons_next),
        .count_next   (count_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            event_reg    <= event_next;
            cursor_x_reg <= x_next;
            cursor_y_reg <= y_next;
            buttons_reg  <= buttons_next;
            count_reg    <= count_next;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_event_res    = event_reg;
    assign m_cursor_x     = cursor_x_reg;
    assign m_cursor_y     = cursor_y_reg;
    assign m_buttons      = buttons_reg;
    assign m_packet_count = count_reg;

    `MPCT_ASSERT_NEXT(a_hold_item, aclk, aresetn, in_valid_reg && !advance, in_valid_reg)
    `MPCT_ASSERT_NEXT(a_result_loads, aclk, aresetn, advance, out_valid_reg)
    `MPCT_ASSERT_NEXT(a_item_taken, aclk, aresetn, s_valid && s_ready, in_valid_reg)

endmodule
